// File: sv/a717sd_pkg.sv
package a717sd_pkg;

  // Largest number of words kept in one subframe
  localparam int unsigned MaxWords = 512;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 12;
  localparam int unsigned IndexW  = 9;
  localparam int unsigned SubW    = 3;
  localparam int unsigned CountW  = 10;

  // Subframe sync patterns
  localparam logic [WordW-1:0] SyncSf1 = 12'h247;
  localparam logic [WordW-1:0] SyncSf2 = 12'h5B8;
  localparam logic [WordW-1:0] SyncSf3 = 12'hA47;
  localparam logic [WordW-1:0] SyncSf4 = 12'hDB8;

  // Subframe numbers; zero means no sync seen yet
  localparam logic [SubW-1:0] SubNone = 3'd0;
  localparam logic [SubW-1:0] Sub1    = 3'd1;
  localparam logic [SubW-1:0] Sub2    = 3'd2;
  localparam logic [SubW-1:0] Sub3    = 3'd3;
  localparam logic [SubW-1:0] Sub4    = 3'd4;

  // One result item
  typedef struct packed {
    logic [WordW-1:0]  word_value;
    logic [IndexW-1:0] word_index;
    logic [SubW-1:0]   subframe_number;
    logic              word_kept;
    logic              is_sync;
    logic              closed_valid;
    logic [CountW-1:0] closed_count;
    logic [SubW-1:0]   closed_subframe;
  } result_t;

  // Map a word to its subframe number, SubNone when it is no sync word
  function automatic logic [SubW-1:0] sync_number(input logic [WordW-1:0] w);
    logic [SubW-1:0] n;
    unique case (w)
      SyncSf1: n = Sub1;
      SyncSf2: n = Sub2;
      SyncSf3: n = Sub3;
      SyncSf4: n = Sub4;
      default: n = SubNone;
    endcase
    return n;
  endfunction

endpackage

// File: sv/a717sd_in_if.sv
interface a717sd_in_if;
  logic                          valid;
  logic                          ready;
  logic [a717sd_pkg::ByteW-1:0]  data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// File: sv/a717sd_out_if.sv
interface a717sd_out_if;
  logic                          valid;
  logic                          ready;
  logic [a717sd_pkg::WordW-1:0]  word_value;
  logic [a717sd_pkg::IndexW-1:0] word_index;
  logic [a717sd_pkg::SubW-1:0]   subframe_number;
  logic                          word_kept;
  logic                          is_sync;
  logic                          closed_valid;
  logic [a717sd_pkg::CountW-1:0] closed_count;
  logic [a717sd_pkg::SubW-1:0]   closed_subframe;

  modport source (
    output valid, output word_value, output word_index, output subframe_number,
    output word_kept, output is_sync, output closed_valid, output closed_count,
    output closed_subframe, input ready
  );
  modport sink (
    input valid, input word_value, input word_index, input subframe_number,
    input word_kept, input is_sync, input closed_valid, input closed_count,
    input closed_subframe, output ready
  );
endinterface

// File: sv/arinc717_subframe_deframer_unit.sv
// A result item is registered on the second byte of a pair. Throughput: one byte item
// per cycle unless the output stalls; one result per two bytes, none for a first byte.
// The rate is set by the single result register, which refills while being drained.
// Reset (rst_ni low, asynchronous): no byte held, count and subframe zero,
// reporting disabled, no result pending.
module arinc717_subframe_deframer_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_data_i,
  a717sd_in_if.sink              in_if,
  a717sd_out_if.source           out_if
);

  logic                               report_enable_q;
  logic                               byte_pending_q;
  logic [a717sd_pkg::ByteW-1:0]       held_byte_q;
  logic [a717sd_pkg::CountW-1:0]      words_q, words_d;
  logic [a717sd_pkg::SubW-1:0]        sub_q, sub_d;
  logic                               out_valid_q;
  a717sd_pkg::result_t                res_q, res_d;

  logic                               accept;
  logic                               word_done;
  logic [a717sd_pkg::WordW-1:0]       word;
  logic [a717sd_pkg::SubW-1:0]        sync_num;
  logic                               full;

  // Accept while the result register is empty or being drained
  assign in_if.ready = !out_valid_q || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;
  assign word_done   = accept && byte_pending_q;

  // Word assembly: low nibble of the held byte above the new byte
  assign word     = {held_byte_q[a717sd_pkg::WordW-a717sd_pkg::ByteW-1:0], in_if.data_byte};
  assign sync_num = a717sd_pkg::sync_number(word);
  assign full     = words_q >= a717sd_pkg::CountW'(a717sd_pkg::MaxWords);

  // Subframe tracking and result formation
  always_comb begin
    words_d             = words_q;
    sub_d               = sub_q;
    res_d               = '0;
    res_d.word_value    = word;
    if (sync_num != a717sd_pkg::SubNone) begin
      res_d.is_sync   = 1'b1;
      res_d.word_kept = 1'b1;
      if (report_enable_q && (words_q != '0)) begin
        res_d.closed_valid    = 1'b1;
        res_d.closed_count    = words_q;
        res_d.closed_subframe = sub_q;
      end
      sub_d   = sync_num;
      words_d = a717sd_pkg::CountW'(1);
    end else if (!full) begin
      res_d.word_index = words_q[a717sd_pkg::IndexW-1:0];
      res_d.word_kept  = 1'b1;
      words_d          = words_q + a717sd_pkg::CountW'(1);
    end
    res_d.subframe_number = sub_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_enable_q <= 1'b0;
      byte_pending_q  <= 1'b0;
      held_byte_q     <= '0;
      words_q         <= '0;
      sub_q           <= a717sd_pkg::SubNone;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        report_enable_q <= cfg_data_i;
      end
      if (accept) begin
        byte_pending_q <= !byte_pending_q;
        if (!byte_pending_q) begin
          held_byte_q <= in_if.data_byte;
        end
      end
      if (word_done) begin
        words_q <= words_d;
        sub_q   <= sub_d;
      end
      if (in_if.ready) begin
        out_valid_q <= word_done;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (word_done) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.word_value      = res_q.word_value;
  assign out_if.word_index      = res_q.word_index;
  assign out_if.subframe_number = res_q.subframe_number;
  assign out_if.word_kept       = res_q.word_kept;
  assign out_if.is_sync         = res_q.is_sync;
  assign out_if.closed_valid    = res_q.closed_valid;
  assign out_if.closed_count    = res_q.closed_count;
  assign out_if.closed_subframe = res_q.closed_subframe;

endmodule

// File: sim/a717sd_deframer_checker.sv
module a717sd_deframer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  a717sd_in_if        in_mon,
  a717sd_out_if       out_mon,
  output int unsigned fail_count_o,
  output int unsigned words_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import a717sd_pkg::*;

  // Largest count the closed-subframe field can carry
  localparam int unsigned CountMax = (1 << CountW) - 1;
  // Mismatch lines printed before going quiet; counting continues regardless
  localparam int unsigned PrintCap = 40;

  // Predictor state
  logic             report_en;
  logic             hi_held;
  logic [ByteW-1:0] hi_byte;
  int unsigned      sf_words;
  logic [SubW-1:0]  sf_num;
  result_t          words_due[$];

  // Subframe number signalled by a sync pattern, SubNone for a data word
  function automatic logic [SubW-1:0] subframe_of_sync(input logic [WordW-1:0] w);
    if (w == SyncSf1) return Sub1;
    if (w == SyncSf2) return Sub2;
    if (w == SyncSf3) return Sub3;
    if (w == SyncSf4) return Sub4;
    return SubNone;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count_o < PrintCap) begin
      $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
    end
    fail_count_o++;
  endtask

  // Advance the deframer by one byte; a completed pair queues one result item
  task automatic deframe_byte(input logic [ByteW-1:0] b);
    logic [WordW-1:0] w;
    logic [SubW-1:0]  hit;
    result_t          r;
    if (!hi_held) begin
      hi_byte = b;
      hi_held = 1'b1;
      return;
    end
    hi_held      = 1'b0;
    w            = {hi_byte[3:0], b};
    hit          = subframe_of_sync(w);
    r            = '0;
    r.word_value = w;
    if (hit != SubNone) begin
      // sync closes the running subframe and opens a new one at index 0
      r.is_sync   = 1'b1;
      r.word_kept = 1'b1;
      if (report_en && sf_words != 0) begin
        r.closed_valid    = 1'b1;
        r.closed_count    = (sf_words > CountMax) ? CountW'(CountMax) : CountW'(sf_words);
        r.closed_subframe = sf_num;
      end
      sf_num   = hit;
      sf_words = 1;
    end else if (sf_words < MaxWords) begin
      r.word_index = IndexW'(sf_words);
      r.word_kept  = 1'b1;
      sf_words++;
    end
    // a full subframe drops the word: index 0, not kept, count unchanged
    r.subframe_number = sf_num;
    words_due.insert(words_due.size(), r);
  endtask

  task automatic check_word(input result_t got);
    result_t want;
    if (words_due.size() == 0) begin
      report_mismatch("result item with none due, word_value", got.word_value, -1);
      return;
    end
    want = words_due.pop_front();
    if (got.word_value !== want.word_value)
      report_mismatch("word_value", got.word_value, want.word_value);
    if (got.word_index !== want.word_index)
      report_mismatch("word_index", got.word_index, want.word_index);
    if (got.subframe_number !== want.subframe_number)
      report_mismatch("subframe_number", got.subframe_number, want.subframe_number);
    if (got.word_kept !== want.word_kept)
      report_mismatch("word_kept", got.word_kept, want.word_kept);
    if (got.is_sync !== want.is_sync)
      report_mismatch("is_sync", got.is_sync, want.is_sync);
    if (got.closed_valid !== want.closed_valid)
      report_mismatch("closed_valid", got.closed_valid, want.closed_valid);
    if (got.closed_count !== want.closed_count)
      report_mismatch("closed_count", got.closed_count, want.closed_count);
    if (got.closed_subframe !== want.closed_subframe)
      report_mismatch("closed_subframe", got.closed_subframe, want.closed_subframe);
  endtask

  // Watch both channels; results are checked before the new byte is taken in
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    if (!rst_ni) begin
      report_en = 1'b0;
      hi_held   = 1'b0;
      hi_byte   = '0;
      sf_words  = 0;
      sf_num    = SubNone;
      words_due.delete();
      fail_count_o = 0;
      words_due_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.word_value      = out_mon.word_value;
        got.word_index      = out_mon.word_index;
        got.subframe_number = out_mon.subframe_number;
        got.word_kept       = out_mon.word_kept;
        got.is_sync         = out_mon.is_sync;
        got.closed_valid    = out_mon.closed_valid;
        got.closed_count    = out_mon.closed_count;
        got.closed_subframe = out_mon.closed_subframe;
        check_word(got);
      end
      if (in_mon.valid && in_mon.ready) deframe_byte(in_mon.data_byte);
      if (cfg_we_i) report_en = cfg_data_i;
      words_due_o <= words_due.size();
    end
  end

endmodule

// File: sim/arinc717_subframe_deframer_unit_test.sv
module arinc717_subframe_deframer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import a717sd_pkg::*;

  localparam int unsigned ResetCycles  = 8;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned TailCycles   = 8;
  localparam int unsigned PhaseBytes   = 120;

  localparam logic ReportOff = 1'b0;
  localparam logic ReportOn  = 1'b1;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_data_i;
  int unsigned fail_count;
  int unsigned words_due;

  // Traffic shaping, shared between stimulus and receiver
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  bit          hold_req  = 1'b0;
  int unsigned bytes_sent = 0;
  bit          odd_byte   = 1'b0;
  int unsigned quiet      = 0;

  a717sd_in_if  in_ch ();
  a717sd_out_if out_ch ();

  arinc717_subframe_deframer_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  a717sd_deframer_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .words_due_o  (words_due)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog: too long without any item moving ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet == QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        repeat (HoldCycles) begin
          out_ch.ready <= 1'b0;
          @(posedge clk_i);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    bytes_sent++;
    odd_byte = ~odd_byte;
  endtask

  // Word as two bytes, high first; the discarded top nibble is random
  task automatic send_word(input logic [WordW-1:0] w);
    send_byte({4'($urandom_range(15)), w[11:8]});
    send_byte(w[7:0]);
  endtask

  // Random data word that is never a sync pattern
  function automatic logic [WordW-1:0] plain_word();
    logic [WordW-1:0] w;
    w = WordW'($urandom_range(4095));
    if (w == SyncSf1 || w == SyncSf2 || w == SyncSf3 || w == SyncSf4) w[0] = ~w[0];
    return w;
  endfunction

  // Well-formed subframe: realign pairing, a random sync, then data words
  task automatic send_subframe(input int unsigned n_words);
    logic [WordW-1:0] sync_w;
    if (odd_byte) send_byte(ByteW'($urandom_range(255)));
    case ($urandom_range(3))
      0:       sync_w = SyncSf1;
      1:       sync_w = SyncSf2;
      2:       sync_w = SyncSf3;
      default: sync_w = SyncSf4;
    endcase
    send_word(sync_w);
    repeat (n_words) send_word(plain_word());
  endtask

  // Drop valid and wait until every expected result item has been taken
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (words_due != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_report(input logic v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly well-formed subframes, some stray bytes and loose words as noise
  task automatic run_phase(input int unsigned snd_pct, input int unsigned rcv_pct,
                           input bit with_hold, input bit with_overflow);
    int unsigned start;
    int unsigned pick;
    send_idle = snd_pct;
    recv_idle = rcv_pct;
    if (with_hold) hold_req = 1'b1;
    if (with_overflow) begin
      // fill one subframe past its limit so words get dropped, then close it
      send_subframe(MaxWords + $urandom_range(3));
      send_subframe($urandom_range(3));
    end
    start = bytes_sent;
    while (bytes_sent - start < PhaseBytes) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_subframe($urandom_range(24));
      end else if (pick < 85) begin
        // stray byte knocks the pairing out of step
        send_byte(ByteW'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(6, 1)) send_word(WordW'($urandom_range(4095)));
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_data_i      <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unsynced words reported as subframe 0, every sync, nibble drop
    write_report(ReportOn);
    send_byte(8'h00); send_byte(8'h00);
    send_byte(8'hFF); send_byte(8'hFF);
    send_byte(8'h02); send_byte(8'h47);
    send_byte(8'hF5); send_byte(8'hB8);
    send_byte(8'h0A); send_byte(8'h47);
    send_byte(8'h8D); send_byte(8'hB8);
    send_byte(8'h7F); send_byte(8'h00);
    drain();
    // Directed: reporting off, and a first byte left held across the pause
    write_report(ReportOff);
    send_byte(8'h0D); send_byte(8'hB8);
    send_byte(8'h12); send_byte(8'h34);
    send_byte(8'h5A);
    drain();

    write_report(ReportOn);
    run_phase(38, 50, 1'b1, 1'b0);
    drain();
    write_report(ReportOff);
    run_phase(50, 38, 1'b0, 1'b0);
    drain();
    write_report(ReportOn);
    run_phase(0, 0, 1'b0, 1'b1);

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (words_due != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
